[sv/cia_pkg.sv]
// Shared types, register offsets and helper functions for the CIA timer block.
package cia_pkg;

  // Command codes carried by each input word
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register offsets in 6526 order
  localparam logic [3:0] ADDR_PRA   = 4'd0;
  localparam logic [3:0] ADDR_PRB   = 4'd1;
  localparam logic [3:0] ADDR_DDRA  = 4'd2;
  localparam logic [3:0] ADDR_DDRB  = 4'd3;
  localparam logic [3:0] ADDR_TA_LO = 4'd4;
  localparam logic [3:0] ADDR_TA_HI = 4'd5;
  localparam logic [3:0] ADDR_TB_LO = 4'd6;
  localparam logic [3:0] ADDR_TB_HI = 4'd7;
  localparam logic [3:0] ADDR_ICR   = 4'd13;
  localparam logic [3:0] ADDR_CRA   = 4'd14;
  localparam logic [3:0] ADDR_CRB   = 4'd15;

  // Reset values
  localparam logic [7:0]  PORT_RST  = 8'hAA;
  localparam logic [15:0] LATCH_RST = 16'hFFFF;

  // Control register bits
  localparam int unsigned CTRL_RUN     = 0;
  localparam int unsigned CTRL_ONESHOT = 3;

  // One input word
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } item_t;

  // One result word
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
  } result_t;

  // Outcome of one timer tick
  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  ctrl;
    logic        zero;
  } tick_res_t;

  // Count a running timer down; reload or stop when it reaches zero
  function automatic tick_res_t timer_tick(logic [15:0] count, logic [7:0] ctrl,
                                           logic [15:0] latch);
    tick_res_t r;
    logic [15:0] dec;
    r.count = count;
    r.ctrl  = ctrl;
    r.zero  = 1'b0;
    dec     = count - 16'd1;
    if (ctrl[CTRL_RUN]) begin
      r.count = dec;
      if (dec == 16'd0) begin
        r.zero = 1'b1;
        if (ctrl[CTRL_ONESHOT]) begin
          r.ctrl = ctrl & 8'hFE;
        end else begin
          r.count = latch;
        end
      end
    end
    return r;
  endfunction

  // Port read: driven bits from the latch, inputs high, then ANDed with pins
  function automatic logic [7:0] port_value(logic [7:0] out_val, logic [7:0] dir,
                                            logic [7:0] pins);
    return ((out_val & dir) | ~dir) & pins;
  endfunction

endpackage

[sv/cia_core.sv]
// Register file, timers and interrupt logic: one word processed per enable.
module cia_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  cia_pkg::item_t  item,
  output cia_pkg::result_t res
);

  logic [7:0]  pa_out_r, pa_out_nxt, pb_out_r, pb_out_nxt;
  logic [7:0]  pa_dir_r, pa_dir_nxt, pb_dir_r, pb_dir_nxt;
  logic [15:0] ta_latch_r, ta_latch_nxt, tb_latch_r, tb_latch_nxt;
  logic [15:0] ta_count_r, ta_count_nxt, tb_count_r, tb_count_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [4:0]  mask_r, mask_nxt;
  logic [7:0]  ta_ctrl_r, ta_ctrl_nxt, tb_ctrl_r, tb_ctrl_nxt;

  cia_pkg::tick_res_t ta_tick, tb_tick;
  logic [1:0]         hit;
  logic               pending;

  // Timer tick results, used only on tick words
  assign ta_tick = cia_pkg::timer_tick(ta_count_r, ta_ctrl_r, ta_latch_r);
  assign tb_tick = cia_pkg::timer_tick(tb_count_r, tb_ctrl_r, tb_latch_r);
  assign hit     = {tb_tick.zero & mask_r[1], ta_tick.zero & mask_r[0]};
  assign pending = |(flags_r & mask_r[1:0]);

  // Decode the word and compute next state and result
  always_comb begin
    pa_out_nxt   = pa_out_r;
    pb_out_nxt   = pb_out_r;
    pa_dir_nxt   = pa_dir_r;
    pb_dir_nxt   = pb_dir_r;
    ta_latch_nxt = ta_latch_r;
    tb_latch_nxt = tb_latch_r;
    ta_count_nxt = ta_count_r;
    tb_count_nxt = tb_count_r;
    flags_nxt    = flags_r;
    mask_nxt     = mask_r;
    ta_ctrl_nxt  = ta_ctrl_r;
    tb_ctrl_nxt  = tb_ctrl_r;
    res          = '0;
    if (fire) begin
      case (item.command)
        cia_pkg::CMD_TICK: begin
          ta_count_nxt  = ta_tick.count;
          ta_ctrl_nxt   = ta_tick.ctrl;
          tb_count_nxt  = tb_tick.count;
          tb_ctrl_nxt   = tb_tick.ctrl;
          flags_nxt     = flags_r | hit;
          res.irq_pulse = |hit;
        end
        cia_pkg::CMD_READ: begin
          case (item.reg_address)
            cia_pkg::ADDR_PRA:
              res.read_data = cia_pkg::port_value(pa_out_r, pa_dir_r, item.port_a_pins);
            cia_pkg::ADDR_PRB:
              res.read_data = cia_pkg::port_value(pb_out_r, pb_dir_r, item.port_b_pins);
            cia_pkg::ADDR_DDRA:  res.read_data = pa_dir_r;
            cia_pkg::ADDR_DDRB:  res.read_data = pb_dir_r;
            cia_pkg::ADDR_TA_LO: res.read_data = ta_count_r[7:0];
            cia_pkg::ADDR_TA_HI: res.read_data = ta_count_r[15:8];
            cia_pkg::ADDR_TB_LO: res.read_data = tb_count_r[7:0];
            cia_pkg::ADDR_TB_HI: res.read_data = tb_count_r[15:8];
            cia_pkg::ADDR_ICR: begin
              res.read_data = {pending, 5'd0, flags_r};
              flags_nxt     = 2'd0;
            end
            cia_pkg::ADDR_CRA:   res.read_data = ta_ctrl_r;
            cia_pkg::ADDR_CRB:   res.read_data = tb_ctrl_r;
            default:             res.read_data = 8'd0;
          endcase
        end
        cia_pkg::CMD_WRITE: begin
          case (item.reg_address)
            cia_pkg::ADDR_PRA:  pa_out_nxt = item.write_data;
            cia_pkg::ADDR_PRB:  pb_out_nxt = item.write_data;
            cia_pkg::ADDR_DDRA: pa_dir_nxt = item.write_data;
            cia_pkg::ADDR_DDRB: pb_dir_nxt = item.write_data;
            cia_pkg::ADDR_TA_LO: begin
              ta_latch_nxt[7:0] = item.write_data;
              ta_count_nxt[7:0] = item.write_data;
            end
            cia_pkg::ADDR_TA_HI: begin
              ta_latch_nxt[15:8] = item.write_data;
              ta_count_nxt[15:8] = item.write_data;
            end
            cia_pkg::ADDR_TB_LO: begin
              tb_latch_nxt[7:0] = item.write_data;
              tb_count_nxt[7:0] = item.write_data;
            end
            cia_pkg::ADDR_TB_HI: begin
              tb_latch_nxt[15:8] = item.write_data;
              tb_count_nxt[15:8] = item.write_data;
            end
            cia_pkg::ADDR_ICR: begin
              // Bit 7 selects set or clear of the named mask bits
              if (item.write_data[7]) begin
                mask_nxt = mask_r | item.write_data[4:0];
              end else begin
                mask_nxt = mask_r & ~item.write_data[4:0];
              end
            end
            cia_pkg::ADDR_CRA: ta_ctrl_nxt = item.write_data;
            cia_pkg::ADDR_CRB: tb_ctrl_nxt = item.write_data;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Hold state between words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_out_r   <= cia_pkg::PORT_RST;
      pb_out_r   <= cia_pkg::PORT_RST;
      pa_dir_r   <= cia_pkg::PORT_RST;
      pb_dir_r   <= cia_pkg::PORT_RST;
      ta_latch_r <= cia_pkg::LATCH_RST;
      tb_latch_r <= cia_pkg::LATCH_RST;
      ta_count_r <= 16'd0;
      tb_count_r <= 16'd0;
      flags_r    <= 2'd0;
      mask_r     <= 5'd0;
      ta_ctrl_r  <= 8'd0;
      tb_ctrl_r  <= 8'd0;
    end else begin
      pa_out_r   <= pa_out_nxt;
      pb_out_r   <= pb_out_nxt;
      pa_dir_r   <= pa_dir_nxt;
      pb_dir_r   <= pb_dir_nxt;
      ta_latch_r <= ta_latch_nxt;
      tb_latch_r <= tb_latch_nxt;
      ta_count_r <= ta_count_nxt;
      tb_count_r <= tb_count_nxt;
      flags_r    <= flags_nxt;
      mask_r     <= mask_nxt;
      ta_ctrl_r  <= ta_ctrl_nxt;
      tb_ctrl_r  <= tb_ctrl_nxt;
    end
  end

`ifndef SYNTHESIS
  // A flag register read leaves no flag behind
  a_icr_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.command == cia_pkg::CMD_READ && item.reg_address == cia_pkg::ADDR_ICR
    |=> flags_r == 2'd0)
    else $error("flags not cleared by ICR read");

  // An interrupt pulse always leaves its flag set
  a_pulse_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.irq_pulse |=> flags_r != 2'd0)
    else $error("irq pulse without flag");

  // Timers only move when a word is processed
  a_idle_timers_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(ta_count_r) && $stable(tb_count_r))
    else $error("timer moved while idle");

  // Interrupt pulses come only from ticks
  a_pulse_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.irq_pulse |-> item.command == cia_pkg::CMD_TICK && mask_r[1:0] != 2'd0)
    else $error("irq pulse outside tick");
`endif

endmodule

[sv/cia_timer_interrupt_ports.sv]
// Top level: input register, processing core and output register of the CIA timer.
// Usage:
//   Input channel in_valid/in_ready carries one word per transfer: a command
//   (tick, register read, register write), a register offset, write data and
//   the external pin levels of ports A and B. Each tick counts down every running timer.
//   Output channel out_valid/out_ready returns one word for every input word:
//   the read data (zero on ticks and writes) and an interrupt pulse flag.
//   Path: an accepted word waits in the input register, and its result then in the
//   output register; a stall on the output can hold the word in between.
//   Throughput: one word per cycle, sustained, while out_ready stays high.
//   The core updates all state in the single cycle a word moves from the
//   input register into the output register.
//   Stall: when out_ready is low the output register holds its word, the
//   input register holds the next one, and in_ready drops once both are full.
//   Reset (rst_n low, synchronous): both pipeline registers empty, ports and
//   direction registers at 0xAA, timer latches at 0xFFFF, counts, flags,
//   mask and control registers at zero.
module cia_timer_interrupt_ports (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [3:0] in_reg_address,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_port_a_pins,
  input  logic [7:0] in_port_b_pins,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq_pulse
);

  logic              s1_valid_r;
  cia_pkg::item_t    s1_item_r;
  logic              out_valid_r;
  cia_pkg::result_t  out_word_r;
  cia_pkg::result_t  core_res;
  logic              advance;
  logic              in_fire;

  // Move a word forward when the output register is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{command:     in_command,
                     reg_address: in_reg_address,
                     write_data:  in_write_data,
                     port_a_pins: in_port_a_pins,
                     port_b_pins: in_port_b_pins};
    end
  end

  cia_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s1_item_r),
    .res   (core_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= core_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_word_r.read_data;
  assign out_irq_pulse = out_word_r.irq_pulse;

`ifndef SYNTHESIS
  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_r))
    else $error("output word dropped under stall");

  // The input register is never overwritten while its word is waiting
  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("pending input word lost");

  // A word entering the core always lands in the output register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result not registered");
`endif

endmodule

[tb/sv/tb_cia_timer_interrupt_ports.sv]
// Self-checking testbench for the CIA timer, interrupt and port block.
`timescale 1ns / 100ps

module tb_cia_timer_interrupt_ports;

  // Codes outside the package: the spare command and the spare address window
  localparam logic [1:0] CMD_NONE      = 2'd3;
  localparam logic [3:0] ADDR_SPARE_LO = 4'd8;
  localparam logic [3:0] ADDR_SPARE_HI = 4'd12;

  localparam int RANDOM_WORDS = 1650;
  localparam int CALM_FIRST   = 800;
  localparam int CALM_LAST    = 1100;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_EVERY  = 400;

  typedef struct {
    cia_pkg::item_t word;
    bit             drain;
  } pending_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_command = cia_pkg::CMD_TICK;
  logic [3:0] in_reg_address = cia_pkg::ADDR_PRA;
  logic [7:0] in_write_data = 8'h00;
  logic [7:0] in_port_a_pins = 8'h00;
  logic [7:0] in_port_b_pins = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq_pulse;

  pending_t         pending_q[$];
  cia_pkg::result_t expected_q[$];
  cia_pkg::item_t   offered;
  int       words_queued = 0;
  int       words_sent = 0;
  int       words_seen = 0;
  int       irq_seen = 0;
  int       flag_reads = 0;
  int       mismatches = 0;
  int       holdoff = 0;
  bit       held_once = 1'b0;

  // Predictor state
  logic [7:0]  pa_out, pb_out, pa_dir, pb_dir;
  logic [15:0] ta_latch, tb_latch, ta_count, tb_count;
  logic [7:0]  flags, ta_ctrl, tb_ctrl;
  logic [4:0]  mask;

  cia_timer_interrupt_ports i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_reg_address (in_reg_address),
    .in_write_data  (in_write_data),
    .in_port_a_pins (in_port_a_pins),
    .in_port_b_pins (in_port_b_pins),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_irq_pulse  (out_irq_pulse)
  );

  always #6 clk = ~clk;

  // Return the predictor to its power-up contents
  task automatic clear_model();
    pa_out   = cia_pkg::PORT_RST;
    pb_out   = cia_pkg::PORT_RST;
    pa_dir   = cia_pkg::PORT_RST;
    pb_dir   = cia_pkg::PORT_RST;
    ta_latch = cia_pkg::LATCH_RST;
    tb_latch = cia_pkg::LATCH_RST;
    ta_count = 16'h0000;
    tb_count = 16'h0000;
    flags    = 8'h00;
    mask     = 5'h00;
    ta_ctrl  = 8'h00;
    tb_ctrl  = 8'h00;
  endtask

  // Advance one timer by a tick; reload or stop at zero, flag if masked in
  task automatic count_down(inout logic [15:0] cnt, inout logic [7:0] ctl,
                            input logic [15:0] lat, input logic [7:0] flag_bit,
                            output bit fired);
    fired = 1'b0;
    if (ctl[cia_pkg::CTRL_RUN]) begin
      cnt = cnt - 16'd1;
      if (cnt == 16'd0) begin
        if (ctl[cia_pkg::CTRL_ONESHOT]) ctl[cia_pkg::CTRL_RUN] = 1'b0;
        else cnt = lat;
        if (({3'b000, mask} & flag_bit) != 8'h00) begin
          flags = flags | flag_bit;
          fired = 1'b1;
        end
      end
    end
  endtask

  // Work out the result word that one accepted input word causes
  task automatic predict_word(input cia_pkg::item_t w, output cia_pkg::result_t r);
    bit fired_a, fired_b;
    logic [7:0] d;
    r.read_data = 8'h00;
    r.irq_pulse = 1'b0;
    d = w.write_data;
    case (w.command)
      cia_pkg::CMD_TICK: begin
        count_down(ta_count, ta_ctrl, ta_latch, 8'h01, fired_a);
        count_down(tb_count, tb_ctrl, tb_latch, 8'h02, fired_b);
        r.irq_pulse = fired_a | fired_b;
      end
      cia_pkg::CMD_READ: begin
        case (w.reg_address)
          cia_pkg::ADDR_PRA:
            r.read_data = ((pa_out & pa_dir) | ~pa_dir) & w.port_a_pins;
          cia_pkg::ADDR_PRB:
            r.read_data = ((pb_out & pb_dir) | ~pb_dir) & w.port_b_pins;
          cia_pkg::ADDR_DDRA:  r.read_data = pa_dir;
          cia_pkg::ADDR_DDRB:  r.read_data = pb_dir;
          cia_pkg::ADDR_TA_LO: r.read_data = ta_count[7:0];
          cia_pkg::ADDR_TA_HI: r.read_data = ta_count[15:8];
          cia_pkg::ADDR_TB_LO: r.read_data = tb_count[7:0];
          cia_pkg::ADDR_TB_HI: r.read_data = tb_count[15:8];
          cia_pkg::ADDR_ICR: begin
            r.read_data = flags;
            if ((flags & {3'b000, mask}) != 8'h00) r.read_data[7] = 1'b1;
            flags = 8'h00;
          end
          cia_pkg::ADDR_CRA:   r.read_data = ta_ctrl;
          cia_pkg::ADDR_CRB:   r.read_data = tb_ctrl;
          default:             r.read_data = 8'h00;
        endcase
      end
      cia_pkg::CMD_WRITE: begin
        case (w.reg_address)
          cia_pkg::ADDR_PRA:   pa_out = d;
          cia_pkg::ADDR_PRB:   pb_out = d;
          cia_pkg::ADDR_DDRA:  pa_dir = d;
          cia_pkg::ADDR_DDRB:  pb_dir = d;
          cia_pkg::ADDR_TA_LO: begin ta_latch[7:0] = d;  ta_count[7:0] = d;  end
          cia_pkg::ADDR_TA_HI: begin ta_latch[15:8] = d; ta_count[15:8] = d; end
          cia_pkg::ADDR_TB_LO: begin tb_latch[7:0] = d;  tb_count[7:0] = d;  end
          cia_pkg::ADDR_TB_HI: begin tb_latch[15:8] = d; tb_count[15:8] = d; end
          cia_pkg::ADDR_ICR: begin
            if (d[7]) mask = mask | d[4:0];
            else mask = mask & ~d[4:0];
          end
          cia_pkg::ADDR_CRA:   ta_ctrl = d;
          cia_pkg::ADDR_CRB:   tb_ctrl = d;
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // Queue one input word; every few hundred words wait for the block to drain
  task automatic queue_word(input logic [1:0] cmd, input logic [3:0] addr,
                            input logic [7:0] data, input logic [7:0] pins_a,
                            input logic [7:0] pins_b);
    pending_t p;
    p.word.command     = cmd;
    p.word.reg_address = addr;
    p.word.write_data  = data;
    p.word.port_a_pins = pins_a;
    p.word.port_b_pins = pins_b;
    p.drain = (words_queued % DRAIN_EVERY) == DRAIN_EVERY - 1;
    pending_q.push_back(p);
    words_queued++;
  endtask

  task automatic queue_write(input logic [3:0] addr, input logic [7:0] data);
    queue_word(cia_pkg::CMD_WRITE, addr, data, 8'($urandom), 8'($urandom));
  endtask

  task automatic queue_read(input logic [3:0] addr);
    queue_word(cia_pkg::CMD_READ, addr, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic queue_tick();
    queue_word(cia_pkg::CMD_TICK, 4'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
  endtask

  // Count and print one mismatch
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("mismatch at word %0d: %s got 0x%02h want 0x%02h", words_seen, what, got,
             want);
  endtask

  // Driver: predict each accepted word, then offer the next or idle
  always @(posedge clk) begin
    bit took, quiet, blocked;
    cia_pkg::result_t res;
    pending_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_model();
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        predict_word(offered, res);
        expected_q.push_back(res);
        words_sent++;
      end
      if (!in_valid || took) begin
        quiet = words_sent >= CALM_FIRST && words_sent < CALM_LAST;
        blocked = pending_q.size() == 0 ||
                  (pending_q[0].drain && expected_q.size() != 0) ||
                  (!quiet && $urandom_range(0, 99) < 31);
        if (blocked) begin
          in_valid <= 1'b0;
        end else begin
          nxt = pending_q.pop_front();
          offered = nxt.word;
          in_valid       <= 1'b1;
          in_command     <= nxt.word.command;
          in_reg_address <= nxt.word.reg_address;
          in_write_data  <= nxt.word.write_data;
          in_port_a_pins <= nxt.word.port_a_pins;
          in_port_b_pins <= nxt.word.port_b_pins;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, a calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff != 0) begin
      out_ready <= 1'b0;
      holdoff <= holdoff - 1;
    end else if (!held_once && words_seen >= HOLD_AT) begin
      out_ready <= 1'b0;
      holdoff <= HOLD_CYCLES;
      held_once <= 1'b1;
    end else begin
      out_ready <= (words_seen >= CALM_FIRST && words_seen < CALM_LAST) ||
                   $urandom_range(0, 99) >= 31;
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    cia_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word, read_data", out_read_data, 8'h00);
      end else begin
        want = expected_q.pop_front();
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", out_read_data, want.read_data);
        if (out_irq_pulse !== want.irq_pulse)
          report_mismatch("irq_pulse", {7'b0, out_irq_pulse}, {7'b0, want.irq_pulse});
        if (want.irq_pulse) irq_seen++;
      end
      words_seen++;
    end
  end

  // Stimulus and end of run
  initial begin
    bit         tsel;
    logic [7:0] ctl;
    int         nt;

    // Port reads at reset values, with pins high and low
    queue_word(cia_pkg::CMD_READ, cia_pkg::ADDR_PRA, 8'h00, 8'hFF, 8'hFF);
    queue_word(cia_pkg::CMD_READ, cia_pkg::ADDR_PRB, 8'hFF, 8'h00, 8'h5A);
    queue_read(cia_pkg::ADDR_DDRB);
    queue_write(cia_pkg::ADDR_DDRA, 8'h00);
    queue_word(cia_pkg::CMD_READ, cia_pkg::ADDR_PRA, 8'h00, 8'hC3, 8'h00);
    // Spare addresses and the spare command
    queue_write(ADDR_SPARE_LO, 8'hFF);
    queue_read(ADDR_SPARE_HI);
    queue_word(CMD_NONE, cia_pkg::ADDR_ICR, 8'hFF, 8'hFF, 8'hFF);
    // One-shot timer A reaching zero with its interrupt masked in
    queue_write(cia_pkg::ADDR_ICR, 8'h83);
    queue_write(cia_pkg::ADDR_TA_LO, 8'h02);
    queue_write(cia_pkg::ADDR_TA_HI, 8'h00);
    queue_write(cia_pkg::ADDR_CRA, 8'h09);
    queue_tick();
    queue_tick();
    queue_read(cia_pkg::ADDR_ICR);
    queue_read(cia_pkg::ADDR_CRA);
    // Continuous timer B reloading every tick
    queue_write(cia_pkg::ADDR_TB_LO, 8'h01);
    queue_write(cia_pkg::ADDR_TB_HI, 8'h00);
    queue_write(cia_pkg::ADDR_CRB, 8'h01);
    queue_tick();
    queue_tick();
    // Running timer at zero wraps without an interrupt
    queue_write(cia_pkg::ADDR_TB_LO, 8'h00);
    queue_tick();
    queue_read(cia_pkg::ADDR_TB_HI);
    // Pending flag with its mask cleared reads without bit 7
    queue_write(cia_pkg::ADDR_ICR, 8'h03);
    queue_read(cia_pkg::ADDR_ICR);

    // Random part: mostly timer programming runs, some noise
    while (words_queued < RANDOM_WORDS + 26) begin
      if ($urandom_range(0, 9) < 7) begin
        tsel = 1'($urandom_range(0, 1));
        queue_write(tsel ? cia_pkg::ADDR_TB_LO : cia_pkg::ADDR_TA_LO,
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
        queue_write(tsel ? cia_pkg::ADDR_TB_HI : cia_pkg::ADDR_TA_HI,
                    ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
        if ($urandom_range(0, 2) == 0) queue_write(cia_pkg::ADDR_ICR, 8'($urandom));
        else if ($urandom_range(0, 3) == 0) queue_write(cia_pkg::ADDR_ICR, 8'h83);
        ctl = 8'($urandom);
        if ($urandom_range(0, 4) != 0) ctl[cia_pkg::CTRL_RUN] = 1'b1;
        queue_write(tsel ? cia_pkg::ADDR_CRB : cia_pkg::ADDR_CRA, ctl);
        nt = $urandom_range(1, 16);
        repeat (nt) queue_tick();
        queue_read(cia_pkg::ADDR_ICR);
        if ($urandom_range(0, 1) == 0) queue_read(4'($urandom_range(0, 15)));
      end else begin
        queue_word(2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all words to be sent and answered, then a few more cycles
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d words: ticks, port, timer and flag accesses, %0d interrupts",
             words_seen, irq_seen);
    $display("including a long receiver hold-off and drains every %0d words", DRAIN_EVERY);
    if (mismatches == 0) begin
      $display("tb_cia_timer_interrupt_ports passed");
    end else begin
      $display("tb_cia_timer_interrupt_ports failed");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #3600000;
    $display("tb_cia_timer_interrupt_ports failed");
    $finish;
  end

endmodule
